[hw/rtl/cdq_pkg.sv]
// Shared types and constants for the circular deque block.
// No dependencies; imported by cdq_ram, cdq_ctrl and circular_deque_top.
package cdq_pkg;

  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Operation codes carried in the kind field
  localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [1:0] KIND_POP_BACK   = 2'd3;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic               is_empty;
    logic               is_full;
    logic        [1:0]  status;
  } rsp_t;

  // One write port and one read port into the ring storage
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } mem_req_t;

endpackage

[hw/rtl/cdq_ram.sv]
// Ring storage: DEPTH x DATA_WIDTH, one write port, one read port, registered read.
// Depends on cdq_pkg.
module cdq_ram
  import cdq_pkg::*;
(
  input  logic                  clk_i,
  input  mem_req_t              mem_req_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rdata_q <= mem[mem_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/cdq_ctrl.sv]
// Deque control: head/tail indices, empty flag, cached end entries, result build.
// Depends on cdq_pkg; drives the cdq_ram port.
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  req_t                  req_i,
  input  logic [DATA_WIDTH-1:0] rdata_i,
  output mem_req_t              mem_req_o,
  output logic                  busy_o,
  output logic                  valid_o,
  output rsp_t                  rsp_o
);

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic logic [31:0] widen(input logic [DATA_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = 64'($signed(v));
    return w[31:0];
  endfunction

  logic [IDX_W-1:0]      head_q, head_d, tail_q, tail_d;
  logic                  empty_q, empty_d;
  logic                  busy_q, busy_d;
  logic                  pend_front_q, pend_front_d;
  logic                  pend_back_q, pend_back_d;
  status_e               status_q, status_d;
  logic [DATA_WIDTH-1:0] front_q, front_d, back_q, back_d;
  logic [DATA_WIDTH-1:0] push_data;
  logic [DATA_WIDTH-1:0] front_cur, back_cur;
  logic                  full;

  assign full      = !empty_q && (idx_inc(tail_q) == head_q);
  assign push_data = DATA_WIDTH'(64'($signed(req_i.value)));
  assign front_cur = pend_front_q ? rdata_i : front_q;
  assign back_cur  = pend_back_q  ? rdata_i : back_q;

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    empty_d      = empty_q;
    busy_d       = busy_q;
    pend_front_d = 1'b0;
    pend_back_d  = 1'b0;
    status_d     = status_q;
    front_d      = front_q;
    back_d       = back_q;
    mem_req_o    = '0;

    if (busy_q) begin
      // retire: fold the fetched entry into the cache
      busy_d  = 1'b0;
      front_d = front_cur;
      back_d  = back_cur;
    end else if (start_i) begin
      busy_d   = 1'b1;
      status_d = ST_DONE;
      unique case (req_i.kind)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else if (empty_q) begin
            head_d          = '0;
            tail_d          = '0;
            empty_d         = 1'b0;
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = '0;
            mem_req_o.wdata = push_data;
            front_d         = push_data;
            back_d          = push_data;
          end else if (req_i.kind == KIND_PUSH_FRONT) begin
            head_d          = idx_dec(head_q);
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = idx_dec(head_q);
            mem_req_o.wdata = push_data;
            front_d         = push_data;
          end else begin
            tail_d          = idx_inc(tail_q);
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = idx_inc(tail_q);
            mem_req_o.wdata = push_data;
            back_d          = push_data;
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          if (empty_q) begin
            status_d = ST_UNDERFLOW;
          end else if (head_q == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else if (req_i.kind == KIND_POP_FRONT) begin
            head_d          = idx_inc(head_q);
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = idx_inc(head_q);
            pend_front_d    = 1'b1;
          end else begin
            tail_d          = idx_dec(tail_q);
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = idx_dec(tail_q);
            pend_back_d     = 1'b1;
          end
        end
        default: begin
          status_d = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      empty_q      <= 1'b1;
      busy_q       <= 1'b0;
      pend_front_q <= 1'b0;
      pend_back_q  <= 1'b0;
      status_q     <= ST_DONE;
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      empty_q      <= empty_d;
      busy_q       <= busy_d;
      pend_front_q <= pend_front_d;
      pend_back_q  <= pend_back_d;
      status_q     <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
  end

  assign busy_o  = busy_q;
  assign valid_o = busy_q;

  always_comb begin
    rsp_o.front_value = empty_q ? '0 : widen(front_cur);
    rsp_o.back_value  = empty_q ? '0 : widen(back_cur);
    rsp_o.is_empty    = empty_q;
    rsp_o.is_full     = full;
    rsp_o.status      = status_q;
  end

endmodule

[hw/rtl/circular_deque_top.sv]
// Circular deque top level: a double-ended queue of DEPTH entries in a ring memory.
// Depends on cdq_pkg, cdq_ram and cdq_ctrl.
//
// Usage:
//   Request channel: drive req_i (kind, value) and raise start while busy is low.
//   The request is taken at that rising edge; busy then stays high for one cycle.
//   Kinds: push front, push back, pop front, pop back. Value is ignored for pops.
//   Result channel: result_valid_o is high for exactly one cycle, the cycle
//   after the request is taken, with rsp_o holding the front and back entries
//   after the operation (zero when empty), the empty and full flags and a
//   status: done, push dropped because full, or pop ignored because empty.
//   The receiver cannot stall; it must take rsp_o in the strobe cycle.
//   A new request is not taken while busy is high, that is until the result is
//   out; this is set by the registered read of the ring memory: a pop
//   fetches the new end entry from the memory and the result waits for it.
//   Pushes write the memory and update the cached end entries at once.
//   Reset (rst_ni low, asynchronous) empties the deque and clears busy and
//   the strobe; the memory itself is not cleared, entries outside the live
//   span are never read.
module circular_deque_top
  import cdq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic result_valid_o,
  output rsp_t rsp_o
);

  mem_req_t              mem_req;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // hold the ring contents; read data is registered in the memory
  cdq_ram u_ram (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

  // advance indices, drop overflowing pushes, ignore empty pops
  cdq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req_i),
    .rdata_i   (mem_rdata),
    .mem_req_o (mem_req),
    .busy_o    (busy),
    .valid_o   (result_valid_o),
    .rsp_o     (rsp_o)
  );

  // A taken request produces a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> result_valid_o)
    else $error("request taken without a result strobe");

  // The result strobe is never held high past its pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  // An empty deque reports zero entries and is never full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.is_empty) |->
      (rsp_o.front_value == '0 && rsp_o.back_value == '0 && !rsp_o.is_full))
    else $error("empty deque reports entries or full");

  // The memory is never written and read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("ring memory written and read together");

endmodule

[test/tb_circular_deque_top.sv]
// Self-checking bench for circular_deque_top: directed and random deque requests,
// each result checked against a local ring model. Needs cdq_pkg and the deque RTL.
module tb_circular_deque_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  localparam int N_RANDOM    = 1100;
  localparam int CYCLE_LIMIT = 100000;
  // Window of accepted requests during which the driver never idles
  localparam int QUIET_FIRST = 350;
  localparam int QUIET_LAST  = 600;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req    = '0;
  logic busy;
  logic result_valid;
  rsp_t rsp;

  circular_deque_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_i          (req),
    .busy           (busy),
    .result_valid_o (result_valid),
    .rsp_o          (rsp)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Requests waiting to be driven, and results still owed by the block
  req_t req_backlog [$];
  rsp_t rsp_due     [$];

  int n_errors   = 0;
  int n_cycles   = 0;
  int n_sent     = 0;
  int n_pushes   = 0;
  int n_pops     = 0;
  int n_dropped  = 0;
  int n_ignored  = 0;
  int n_filled   = 0;
  int n_drained  = 0;

  logic [31:0] corner_vals [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};

  // ---------------------------------------------------------------------------
  // Ring model: slots plus front/back indices and an empty flag. Slots are only
  // read between front and back, so their unwritten contents never matter.
  // ---------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] slots [DEPTH];
  int                    front_idx  = 0;
  int                    back_idx   = 0;
  bit                    ring_empty = 1'b1;

  function automatic int next_slot(int i);
    return (i >= DEPTH - 1) ? 0 : i + 1;
  endfunction

  function automatic int prev_slot(int i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  function automatic bit ring_full();
    return !ring_empty && next_slot(back_idx) == front_idx;
  endfunction

  // Sign-extend (or truncate) a stored entry to the 32-bit result field
  function automatic logic [31:0] widen(logic [DATA_WIDTH-1:0] e);
    logic [31:0] w;
    for (int b = 0; b < 32; b++) w[b] = (b < DATA_WIDTH) ? e[b] : e[DATA_WIDTH-1];
    return w;
  endfunction

  // Apply one request to the model and return the result it must produce
  function automatic rsp_t predict_deque_step(req_t r);
    rsp_t o;
    o = '0;
    o.status = ST_DONE;
    if (r.kind == KIND_PUSH_FRONT || r.kind == KIND_PUSH_BACK) begin
      if (ring_full()) begin
        o.status = ST_OVERFLOW;
      end else if (ring_empty) begin
        // First entry always lands in slot zero
        front_idx  = 0;
        back_idx   = 0;
        ring_empty = 1'b0;
        slots[0]   = DATA_WIDTH'(r.value);
      end else if (r.kind == KIND_PUSH_FRONT) begin
        front_idx        = prev_slot(front_idx);
        slots[front_idx] = DATA_WIDTH'(r.value);
      end else begin
        back_idx        = next_slot(back_idx);
        slots[back_idx] = DATA_WIDTH'(r.value);
      end
    end else begin
      if (ring_empty) begin
        o.status = ST_UNDERFLOW;
      end else if (front_idx == back_idx) begin
        // Last entry leaves: indices return home
        front_idx  = 0;
        back_idx   = 0;
        ring_empty = 1'b1;
      end else if (r.kind == KIND_POP_FRONT) begin
        front_idx = next_slot(front_idx);
      end else begin
        back_idx = prev_slot(back_idx);
      end
    end
    if (!ring_empty) begin
      o.front_value = widen(slots[front_idx]);
      o.back_value  = widen(slots[back_idx]);
    end
    o.is_empty = ring_empty;
    o.is_full  = ring_full();
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: hold start and req until the block takes the request, then either
  // present the next one at once or idle at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    rsp_t want;
    bit   lazy;
    if (!rst_ni) begin
      start <= 1'b0;
      req   <= '0;
    end else begin
      if (start && !busy) begin
        want = predict_deque_step(req);
        rsp_due.push_back(want);
        n_sent++;
        if (req.kind == KIND_PUSH_FRONT || req.kind == KIND_PUSH_BACK) begin
          n_pushes++;
          if (want.status == ST_OVERFLOW) n_dropped++;
          else if (want.is_full) n_filled++;
        end else begin
          n_pops++;
          if (want.status == ST_UNDERFLOW) n_ignored++;
          else if (want.is_empty) n_drained++;
        end
      end
      // Slot is free when nothing is pending or the pending request just went in
      if (!(start && busy)) begin
        lazy = !(n_sent >= QUIET_FIRST && n_sent < QUIET_LAST) &&
               ($urandom_range(99) < 24);
        if (req_backlog.size() != 0 && !lazy) begin
          start <= 1'b1;
          req   <= req_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobe must match the oldest owed result, field by field.
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_proc
    rsp_t want;
    if (rst_ni && result_valid) begin
      if (rsp_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %p", $time, rsp);
        n_errors++;
      end else begin
        want = rsp_due.pop_front();
        compare_field("front_value", want.front_value, rsp.front_value);
        compare_field("back_value",  want.back_value,  rsp.back_value);
        compare_field("is_empty",    32'(want.is_empty), 32'(rsp.is_empty));
        compare_field("is_full",     32'(want.is_full),  32'(rsp.is_full));
        compare_field("status",      32'(want.status),   32'(rsp.status));
      end
    end
  end

  // Watchdog: give up if the run hangs
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d requests queued, %0d results owed",
               $time, req_backlog.size(), rsp_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_req(logic [1:0] k, logic [31:0] v);
    req_t r;
    r.kind  = k;
    r.value = v;
    req_backlog.push_back(r);
  endtask

  // Mostly full-range data, with corners and small signed values mixed in
  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return corner_vals[$urandom_range(5)];
    if (roll < 25) return int'($urandom_range(15)) - 8;
    return $urandom();
  endfunction

  initial begin
    int made;
    int mode;
    int run;
    int roll;
    bit push;

    // Directed: pops on empty, single-entry round trip, fill from both ends
    // with corner data, pushes on full, then drain alternately to empty.
    add_req(KIND_POP_FRONT, 32'h1234_5678);
    add_req(KIND_POP_BACK, 32'hFFFF_FFFF);
    add_req(KIND_PUSH_BACK, 32'h7FFF_FFFF);
    add_req(KIND_POP_BACK, 32'h0);
    add_req(KIND_PUSH_FRONT, 32'h8000_0000);
    for (int i = 1; i < DEPTH; i++) begin
      add_req((i % 2) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, corner_vals[i % 6]);
    end
    add_req(KIND_PUSH_FRONT, 32'd123);
    add_req(KIND_PUSH_BACK, 32'hFFFF_FFFB);
    for (int i = 0; i < DEPTH; i++) begin
      add_req((i % 2) ? KIND_POP_BACK : KIND_POP_FRONT, corner_vals[(i + 3) % 6]);
    end
    add_req(KIND_POP_FRONT, 32'h0);

    // Random: bursts biased toward filling, draining or neither, so the ring
    // keeps wrapping and hits both full and empty many times.
    made = 0;
    while (made < N_RANDOM) begin
      mode = $urandom_range(2);
      run  = $urandom_range(8, 40);
      for (int j = 0; j < run; j++) begin
        roll = $urandom_range(99);
        case (mode)
          0:       push = (roll < 80);
          1:       push = (roll < 20);
          default: push = (roll < 50);
        endcase
        if (push) add_req($urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, pick_value());
        else      add_req($urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT, $urandom());
        made++;
      end
    end

    // Hold reset, then release it on a clock edge
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Poll on the falling edge so queue and start have settled
    while (req_backlog.size() != 0 || start) @(negedge clk_i);
    while (rsp_due.size() != 0) @(negedge clk_i);
    // Keep watching for stray strobes before the summary
    repeat (4) @(posedge clk_i);

    $display("Ran %0d requests: %0d pushes (%0d dropped on full), %0d pops (%0d on empty).",
             n_sent, n_pushes, n_dropped, n_pops, n_ignored);
    $display("The ring filled up %0d times and drained to empty %0d times.",
             n_filled, n_drained);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ram.sv
hw/rtl/cdq_ctrl.sv
hw/rtl/circular_deque_top.sv
test/tb_circular_deque_top.sv
